>>> rtl/core/cbm_pkg.sv
// Package: types, codes and reset constants for the cartridge bank mapper.
`default_nettype none
package cbm_pkg;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned OFFS_W   = 23;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [OFFS_W-1:0] ROM_MASK_RESET = 23'h7F_FFFF;
  localparam logic [BYTE_W-1:0] RAM_MASK_RESET = 8'h00;

  // Unlocked ROM reads land in the top 32 KB of the largest image.
  localparam logic [BYTE_W-1:0] TOP_BANK_32K = 8'hFF;
  localparam logic [3:0]        RAM_EN_KEY   = 4'hA;

  // Register index (paddr[2])
  localparam logic REG_ROM_MASK = 1'b0;
  localparam logic REG_RAM_MASK = 1'b1;

  // 8 KB regions of the CPU bus, address[15:13]
  localparam logic [2:0] REGION_LOCK   = 3'd0;
  localparam logic [2:0] REGION_BANK   = 3'd1;
  localparam logic [2:0] REGION_RAMSEL = 3'd2;
  localparam logic [2:0] REGION_CRAM   = 3'd5;

  typedef enum logic [1:0] {
    TGT_ROM_READ  = 2'd0,
    TGT_RAM_READ  = 2'd1,
    TGT_RAM_WRITE = 2'd2,
    TGT_NONE      = 2'd3
  } cbm_target_t;

  typedef enum logic {
    KIND_READ  = 1'b0,
    KIND_WRITE = 1'b1
  } cbm_kind_t;

  typedef struct packed {
    cbm_kind_t         kind;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] data;
  } cbm_in_t;

  typedef struct packed {
    cbm_target_t       target;
    logic [OFFS_W-1:0] mapped_address;
    logic [BYTE_W-1:0] write_byte;
  } cbm_out_t;

endpackage
`default_nettype wire

>>> rtl/core/cbm_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
`default_nettype none
interface cbm_stream_if #(
  parameter type payload_t = cbm_pkg::cbm_in_t
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/core/cartridge_bank_mapper_with_lock.sv
// An accepted access has its result in the output register in the next cycle.
// Throughput: one access per cycle; the output register takes a new result in the
// same cycle its previous one is taken, so input stalls only while output stalls.
// Bank register writes take effect for the very next access.
// Reset (rst_n low, synchronous): banks, RAM enable and lock cleared, masks to defaults.
`default_nettype none
module cartridge_bank_mapper_with_lock (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  cbm_stream_if.sink                        in_ch,
  cbm_stream_if.source                      out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cbm_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [cbm_pkg::PDATA_W-1:0]  pwdata,
  output logic      [cbm_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);

  localparam int unsigned OW = cbm_pkg::OFFS_W;
  localparam int unsigned BW = cbm_pkg::BYTE_W;

  logic [OW-1:0] rom_mask_r;
  logic [BW-1:0] ram_mask_r;
  logic [BW-1:0] outer_bank_r, outer_bank_nxt;
  logic [BW-1:0] inner_bank_r, inner_bank_nxt;
  logic [BW-1:0] cram_bank_r,  cram_bank_nxt;
  logic          ram_en_r,     ram_en_nxt;
  logic          lock_r,       lock_nxt;

  logic              out_valid_r;
  cbm_pkg::cbm_out_t out_payload_r, result_nxt;

  logic          in_fire;
  logic          cfg_wr;
  logic [2:0]    region;
  logic [BW:0]   bank_sum;
  logic [OW-1:0] rom_base;
  logic [OW-1:0] rom_offs;
  logic [OW-1:0] ram_offs;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_payload_r;

  always_comb begin
    unique case (paddr[2])
      cbm_pkg::REG_ROM_MASK: prdata = {{(cbm_pkg::PDATA_W-OW){1'b0}}, rom_mask_r};
      cbm_pkg::REG_RAM_MASK: prdata = {{(cbm_pkg::PDATA_W-BW){1'b0}}, ram_mask_r};
      default:               prdata = '0;
    endcase
  end

  // Address mapping
  assign region   = in_ch.payload.address[15:13];
  assign bank_sum = {1'b0, outer_bank_r} + {1'b0, inner_bank_r};

  always_comb begin
    if (!lock_r) begin
      rom_base = {cbm_pkg::TOP_BANK_32K, 15'd0} & rom_mask_r;
      rom_offs = rom_base + {8'd0, in_ch.payload.address[14:0]};
    end else if (!in_ch.payload.address[14]) begin
      rom_base = {1'b0, outer_bank_r, 14'd0} & rom_mask_r;
      rom_offs = rom_base + {9'd0, in_ch.payload.address[13:0]};
    end else begin
      rom_base = {bank_sum, 14'd0} & rom_mask_r;
      rom_offs = rom_base + {9'd0, in_ch.payload.address[13:0]};
    end
  end

  assign ram_offs = {2'd0, cram_bank_r & ram_mask_r, in_ch.payload.address[12:0]};

  always_comb begin
    outer_bank_nxt = outer_bank_r;
    inner_bank_nxt = inner_bank_r;
    cram_bank_nxt  = cram_bank_r;
    ram_en_nxt     = ram_en_r;
    lock_nxt       = lock_r;
    result_nxt.target         = cbm_pkg::TGT_NONE;
    result_nxt.mapped_address = '0;
    result_nxt.write_byte     = '0;
    if (in_ch.payload.kind == cbm_pkg::KIND_READ) begin
      if (!in_ch.payload.address[15]) begin
        result_nxt.target         = cbm_pkg::TGT_ROM_READ;
        result_nxt.mapped_address = rom_offs;
      end else if (region == cbm_pkg::REGION_CRAM) begin
        result_nxt.target         = cbm_pkg::TGT_RAM_READ;
        result_nxt.mapped_address = ram_offs;
      end
    end else begin
      unique case (region)
        cbm_pkg::REGION_LOCK: begin
          if (lock_r) ram_en_nxt = (in_ch.payload.data[3:0] == cbm_pkg::RAM_EN_KEY);
          else        lock_nxt   = 1'b1;
        end
        cbm_pkg::REGION_BANK: begin
          if (lock_r) inner_bank_nxt = in_ch.payload.data;
          else        outer_bank_nxt = in_ch.payload.data;
        end
        cbm_pkg::REGION_RAMSEL: begin
          if (lock_r) cram_bank_nxt = in_ch.payload.data;
        end
        cbm_pkg::REGION_CRAM: begin
          if (ram_en_r) begin
            result_nxt.target         = cbm_pkg::TGT_RAM_WRITE;
            result_nxt.mapped_address = ram_offs;
            result_nxt.write_byte     = in_ch.payload.data;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_mask_r   <= cbm_pkg::ROM_MASK_RESET;
      ram_mask_r   <= cbm_pkg::RAM_MASK_RESET;
      outer_bank_r <= '0;
      inner_bank_r <= '0;
      cram_bank_r  <= '0;
      ram_en_r     <= 1'b0;
      lock_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          cbm_pkg::REG_ROM_MASK: rom_mask_r <= pwdata[OW-1:0];
          cbm_pkg::REG_RAM_MASK: ram_mask_r <= pwdata[BW-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        outer_bank_r <= outer_bank_nxt;
        inner_bank_r <= inner_bank_nxt;
        cram_bank_r  <= cram_bank_nxt;
        ram_en_r     <= ram_en_nxt;
        lock_r       <= lock_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_payload_r <= result_nxt;
  end

  // Checks
  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(lock_r))
    else $error("lock cleared without reset");

  a_lock_set: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.payload.kind == cbm_pkg::KIND_WRITE) &&
    (region == cbm_pkg::REGION_LOCK) |=> lock_r)
    else $error("lock not set by write to lock region");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_payload_r.target == cbm_pkg::TGT_NONE) |->
    (out_payload_r.mapped_address == '0) && (out_payload_r.write_byte == '0))
    else $error("non-access result carries address or data");

  a_write_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (result_nxt.target == cbm_pkg::TGT_RAM_WRITE) |-> ram_en_r)
    else $error("RAM write issued while RAM disabled");

endmodule
`default_nettype wire

>>> dv/cartridge_bank_mapper_with_lock_tb.sv
// Testbench for the cartridge bank mapper: directed and random bus accesses, scoreboard check.
`timescale 1ns / 100ps

module cartridge_bank_mapper_with_lock_tb;
  import cbm_pkg::*;

  localparam int CYCLE_LIMIT      = 300000;
  localparam int SETTLE_CYCLES    = 4;
  localparam int HOLD_CYCLES      = 80;
  localparam int SHOW_LIMIT       = 10;
  localparam int RANDOM_PER_PHASE = 250;
  localparam int PHASES           = 5;

  // Mirrors the mapper state and keeps the expected mapping of each accepted access.
  class bank_map_checker;
    logic [OFFS_W-1:0] rom_mask = ROM_MASK_RESET;
    logic [BYTE_W-1:0] ram_mask = RAM_MASK_RESET;
    logic [BYTE_W-1:0] outer_bank = '0;
    logic [BYTE_W-1:0] inner_bank = '0;
    logic [BYTE_W-1:0] cram_bank = '0;
    bit                ram_on = 1'b0;
    bit                locked = 1'b0;
    cbm_out_t          pending_maps[$];
    int                mismatches = 0;

    function void write_register(logic sel, logic [PDATA_W-1:0] value);
      if (sel == REG_ROM_MASK) rom_mask = value[OFFS_W-1:0];
      else ram_mask = value[BYTE_W-1:0];
    endfunction

    function logic [OFFS_W-1:0] rom_offset(logic [ADDR_W-1:0] a);
      logic [31:0] base;
      logic [31:0] off;
      logic [31:0] sum;
      if (!locked) begin
        base = (32'(TOP_BANK_32K) << 15) & 32'(rom_mask);
        off  = 32'(a[14:0]);
      end else if (!a[14]) begin
        base = (32'(outer_bank) << 14) & 32'(rom_mask);
        off  = 32'(a);
      end else begin
        base = ((32'(outer_bank) + 32'(inner_bank)) << 14) & 32'(rom_mask);
        off  = 32'(a) - 32'h4000;
      end
      sum = base + off;
      return sum[OFFS_W-1:0];
    endfunction

    function logic [OFFS_W-1:0] ram_offset(logic [ADDR_W-1:0] a);
      return OFFS_W'({cram_bank & ram_mask, a[12:0]});
    endfunction

    function cbm_out_t map_access(cbm_in_t acc);
      cbm_out_t    res;
      logic [2:0]  region;
      region             = acc.address[15:13];
      res.target         = TGT_NONE;
      res.mapped_address = '0;
      res.write_byte     = '0;
      if (acc.kind == KIND_READ) begin
        if (!acc.address[15]) begin
          res.target         = TGT_ROM_READ;
          res.mapped_address = rom_offset(acc.address);
        end else if (region == REGION_CRAM) begin
          // reported as a RAM read even while RAM is disabled
          res.target         = TGT_RAM_READ;
          res.mapped_address = ram_offset(acc.address);
        end
      end else begin
        case (region)
          REGION_LOCK: begin
            if (locked) ram_on = (acc.data[3:0] == RAM_EN_KEY);
            else locked = 1'b1;
          end
          REGION_BANK: begin
            if (locked) inner_bank = acc.data;
            else outer_bank = acc.data;
          end
          REGION_RAMSEL: begin
            if (locked) cram_bank = acc.data;
          end
          REGION_CRAM: begin
            if (ram_on) begin
              res.target         = TGT_RAM_WRITE;
              res.mapped_address = ram_offset(acc.address);
              res.write_byte     = acc.data;
            end
          end
          default: ;
        endcase
      end
      return res;
    endfunction

    function void note_access(cbm_in_t acc);
      pending_maps.push_back(map_access(acc));
    endfunction

    function void check_mapping(cbm_out_t got);
      cbm_out_t want;
      if (pending_maps.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("mismatch: unexpected result target=%0d addr=%06h byte=%02h",
                   got.target, got.mapped_address, got.write_byte);
        return;
      end
      want = pending_maps.pop_front();
      if (got.target !== want.target || got.mapped_address !== want.mapped_address ||
          got.write_byte !== want.write_byte) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("mismatch: expected target=%0d addr=%06h byte=%02h, got target=%0d addr=%06h byte=%02h",
                   want.target, want.mapped_address, want.write_byte,
                   got.target, got.mapped_address, got.write_byte);
      end
    endfunction

    function int pending();
      return pending_maps.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  bank_map_checker tracker = new;

  cbm_stream_if #(.payload_t(cbm_in_t))  in_ch ();
  cbm_stream_if #(.payload_t(cbm_out_t)) out_ch ();

  cartridge_bank_mapper_with_lock dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("cartridge_bank_mapper_with_lock verification failed");
    $finish;
  end

  // Result side: check each transaction, stall at random or for a requested hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) tracker.check_mapping(out_ch.payload);
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic cbm_in_t mk(cbm_kind_t k, logic [ADDR_W-1:0] a, logic [BYTE_W-1:0] d);
    cbm_in_t acc;
    acc.kind    = k;
    acc.address = a;
    acc.data    = d;
    return acc;
  endfunction

  // Mostly well-formed register and memory traffic, the rest fully random.
  function automatic cbm_in_t random_access();
    cbm_in_t acc;
    int      pick;
    pick     = $urandom_range(99);
    acc.kind = KIND_WRITE;
    acc.data = BYTE_W'($urandom);
    if (pick < 25) begin
      acc.kind    = KIND_READ;
      acc.address = {1'b0, 15'($urandom)};
    end else if (pick < 40) begin
      acc.kind    = KIND_READ;
      acc.address = {REGION_CRAM, 13'($urandom)};
    end else if (pick < 50) begin
      acc.address = {REGION_LOCK, 13'($urandom)};
      if ($urandom_range(1)) acc.data[3:0] = RAM_EN_KEY;
    end else if (pick < 62) begin
      acc.address = {REGION_BANK, 13'($urandom)};
    end else if (pick < 70) begin
      acc.address = {REGION_RAMSEL, 13'($urandom)};
    end else if (pick < 88) begin
      acc.address = {REGION_CRAM, 13'($urandom)};
    end else begin
      acc.kind    = cbm_kind_t'($urandom_range(1));
      acc.address = ADDR_W'($urandom);
    end
    return acc;
  endfunction

  task automatic send_access(input cbm_in_t acc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= acc;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_access(acc);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // idle cycle so back-to-back writes never drive the bus twice in one step
    @(posedge clk);
    tracker.write_register(sel, value);
  endtask

  initial begin
    cbm_in_t           directed[$];
    logic [OFFS_W-1:0] rom_val;
    logic [BYTE_W-1:0] ram_val;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // unlocked window under a reduced ROM size
    write_reg(REG_ROM_MASK, 32'h000F_FFFF);
    write_reg(REG_RAM_MASK, 32'h0000_00FF);
    send_access(mk(KIND_READ, 16'h0000, 8'h00));
    send_access(mk(KIND_READ, 16'h7FFF, 8'hFF));
    wait_drained();
    write_reg(REG_ROM_MASK, 32'h007F_FFFF);

    // before the lock: ignored writes, outer bank, then lock
    directed.push_back(mk(KIND_READ,  16'h0000, 8'h00));
    directed.push_back(mk(KIND_READ,  16'h7FFF, 8'hFF));
    directed.push_back(mk(KIND_READ,  16'hA000, 8'h00));
    directed.push_back(mk(KIND_WRITE, 16'hA123, 8'h55));
    directed.push_back(mk(KIND_WRITE, 16'h4000, 8'h03));
    directed.push_back(mk(KIND_WRITE, 16'h6000, 8'hFF));
    directed.push_back(mk(KIND_READ,  16'h8000, 8'h00));
    directed.push_back(mk(KIND_READ,  16'hFFFF, 8'h00));
    directed.push_back(mk(KIND_WRITE, 16'hC000, 8'h77));
    directed.push_back(mk(KIND_WRITE, 16'h2000, 8'h00));
    directed.push_back(mk(KIND_WRITE, 16'h3FFF, 8'hFF));
    directed.push_back(mk(KIND_READ,  16'h4000, 8'h00));
    directed.push_back(mk(KIND_WRITE, 16'h0000, 8'h00));
    // locked: lower ROM window at the largest outer bank, upper at the largest bank sum, RAM enable and banking
    directed.push_back(mk(KIND_READ,  16'h0000, 8'h00));
    directed.push_back(mk(KIND_READ,  16'h3FFF, 8'h00));
    directed.push_back(mk(KIND_WRITE, 16'h2000, 8'hFF));
    directed.push_back(mk(KIND_READ,  16'h7FFF, 8'h00));
    directed.push_back(mk(KIND_READ,  16'h4000, 8'h00));
    directed.push_back(mk(KIND_WRITE, 16'h1FFF, 8'h0A));
    directed.push_back(mk(KIND_WRITE, 16'h5FFF, 8'hFF));
    directed.push_back(mk(KIND_WRITE, 16'hBFFF, 8'hA5));
    directed.push_back(mk(KIND_READ,  16'hA000, 8'h00));
    directed.push_back(mk(KIND_WRITE, 16'h0000, 8'h0B));
    directed.push_back(mk(KIND_WRITE, 16'hA000, 8'h12));
    directed.push_back(mk(KIND_READ,  16'hBFFF, 8'h00));
    foreach (directed[i]) send_access(directed[i]);
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          rom_val = '0;
          ram_val = '0;
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          rom_val = 23'h1F_FFFF;
          ram_val = 8'h0F;
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          rom_val = OFFS_W'($urandom);
          ram_val = BYTE_W'($urandom);
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
        3: begin
          rom_val = 23'h7F_FFFF;
          ram_val = 8'hFF;
          send_idle_pct  = 7;
          recv_stall_pct = 7;
        end
        default: begin
          rom_val = OFFS_W'($urandom);
          ram_val = BYTE_W'($urandom);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      write_reg(REG_ROM_MASK, PDATA_W'(rom_val));
      write_reg(REG_RAM_MASK, PDATA_W'(ram_val));
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        // long output hold-off while input keeps coming, so the input backs up
        if (phase == PHASES - 1 && i == 40) hold_asked++;
        if (phase == 1 && i == RANDOM_PER_PHASE / 2) wait_drained();
        send_access(random_access());
      end
      wait_drained();
    end

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("cartridge_bank_mapper_with_lock verification clean");
    end else begin
      $display("cartridge_bank_mapper_with_lock verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/cbm_pkg.sv
rtl/core/cbm_stream_if.sv
rtl/core/cartridge_bank_mapper_with_lock.sv
dv/cartridge_bank_mapper_with_lock_tb.sv
